>>> rtl/core/hydronic_zone_balancer_defines.svh
// Assertion macros used by the balancer top level.
`ifndef HYDRONIC_ZONE_BALANCER_DEFINES_SVH
`define HYDRONIC_ZONE_BALANCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HZB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hzb check failed");

// Next-cycle implication, disabled during reset.
`define HZB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hzb check failed");

`endif

>>> rtl/core/hzb_pkg.sv
`timescale 1ns / 1ps
package hzb_pkg;
   localparam int ZONES_DEF = 6;
   localparam int NUM_W = 53;
   localparam int DEN_W = 35;
   localparam int LEN_W = 20;
   localparam int FAC_W = 17;
   localparam int P1_W = 31;
   localparam int P2_W = 51;

   localparam logic [FAC_W-1:0] Q16_ONE = 17'd65536;
   localparam logic [FAC_W-1:0] FC_MAX = 17'd104858;
   localparam logic [FAC_W-1:0] HP_MIN = 17'd16384;
   localparam logic [LEN_W-1:0] LEN_DEFAULT = 20'd100;

   localparam logic [1:0] CSR_BAND = 2'd0;
   localparam logic [1:0] CSR_MAINT = 2'd1;
   localparam logic [1:0] CSR_PROFILE = 2'd2;
   localparam logic [1:0] PROF_HEAT_PUMP = 2'd1;

   localparam logic [9:0] BAND_RST = 10'd50;
   localparam logic [13:0] MAINT_RST = 14'd10000;

   typedef enum logic [1:0] {
      ST_OVER = 2'd0,
      ST_SAT = 2'd1,
      ST_DEMAND = 2'd2,
      ST_UNKNOWN = 2'd3
   } zstate_type;

   typedef struct packed {
      logic               tvalid;
      logic signed [14:0] cur;
      logic signed [14:0] tgt;
      logic [15:0]        area;
      logic [9:0]         spacing;
      logic [2:0]         pkind;
      logic [1:0]         fkind;
      logic               thvalid;
      logic [9:0]         thick;
   } zone_rec_type;

   typedef struct packed {
      logic busy;
      logic clear;
   } back_stat_type;

   // round(65536*sqrt(12/d)) per pipe code, unused codes as 12 mm
   function automatic logic [FAC_W-1:0] pipe_gain(input logic [2:0] kind);
      logic [FAC_W-1:0] v;
      case (kind)
         3'd1: v = 17'd80265;
         3'd2: v = 17'd71791;
         3'd4: v = 17'd62965;
         3'd5: v = 17'd60675;
         3'd6: v = 17'd56756;
         default: v = 17'd65536;
      endcase
      return v;
   endfunction

   // floor conductivity in mW/mK
   function automatic logic [10:0] floor_k(input logic [1:0] kind);
      logic [10:0] v;
      case (kind)
         2'd1: v = 11'd130;
         2'd2: v = 11'd180;
         2'd3: v = 11'd90;
         default: v = 11'd1300;
      endcase
      return v;
   endfunction
endpackage

>>> rtl/core/hydronic_zone_balancer.sv
`timescale 1ns / 1ps
// Records are taken one a cycle while req_full is low; the record marked last closes the
// cycle and holds req_full until every result of that cycle has been written to the two-entry
// result queue. Back part starts at the edge after the closing record. First pass: each zone
// slot is classified, its pipe length worked out by the 53-step radix-2 divider where needed.
// Second pass: skip unloaded, zero overheated, else floor/valve divisions; full-queue stalls.
// Reset (synchronous, active high) restores the register defaults, clears latches and queues.
`include "hydronic_zone_balancer_defines.svh"
module hydronic_zone_balancer #(
   parameter int ZONES = hzb_pkg::ZONES_DEF,
   parameter int ZW = $clog2(ZONES + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [ZW-1:0]             req_zone_index,
   input  logic                      req_temps_valid,
   input  logic signed [14:0]        req_current_temp,
   input  logic signed [14:0]        req_target_temp,
   input  logic [15:0]               req_floor_area,
   input  logic [9:0]                req_pipe_spacing,
   input  logic [2:0]                req_pipe_kind,
   input  logic [1:0]                req_floor_kind,
   input  logic                      req_thickness_valid,
   input  logic [9:0]                req_cover_thickness,
   input  logic                      req_last,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [ZW-1:0]             rsp_out_zone,
   output logic [1:0]                rsp_zone_state,
   output logic [hzb_pkg::FAC_W-1:0] rsp_valve_factor,
   output logic [ZW-1:0]             rsp_reference_zone,
   output logic                      rsp_out_last,
   input  logic                      csr_write_en,
   input  logic [1:0]                csr_index,
   input  logic [13:0]               csr_wdata
);
   localparam int IW = (ZONES > 1) ? $clog2(ZONES) : 1;
   localparam int RW = 2 * ZW + hzb_pkg::FAC_W + 3;

   logic [9:0]  band_ff;
   logic [13:0] maint_ff;
   logic [1:0]  prof_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= hzb_pkg::BAND_RST;
         maint_ff <= hzb_pkg::MAINT_RST;
         prof_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            hzb_pkg::CSR_BAND: band_ff <= csr_wdata[9:0];
            hzb_pkg::CSR_MAINT: maint_ff <= csr_wdata;
            hzb_pkg::CSR_PROFILE: prof_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   hzb_pkg::zone_rec_type rec_wr, rd_rec;
   hzb_pkg::back_stat_type stat;
   logic [IW-1:0] rd_idx;
   logic [ZONES-1:0] loaded;
   logic start;

   always_comb begin
      rec_wr.tvalid = req_temps_valid;
      rec_wr.cur = req_current_temp;
      rec_wr.tgt = req_target_temp;
      rec_wr.area = req_floor_area;
      rec_wr.spacing = req_pipe_spacing;
      rec_wr.pkind = req_pipe_kind;
      rec_wr.fkind = req_floor_kind;
      rec_wr.thvalid = req_thickness_valid;
      rec_wr.thick = req_cover_thickness;
   end

   hzb_front #(
      .ZONES(ZONES),
      .ZW(ZW),
      .IW(IW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .push(req_push),
      .full(req_full),
      .zone_index(req_zone_index),
      .rec_wr(rec_wr),
      .last(req_last),
      .rd_idx(rd_idx),
      .rd_rec(rd_rec),
      .loaded(loaded),
      .start(start),
      .stat(stat)
   );

   logic bk_valid, ofifo_full;
   logic [ZW-1:0] bk_zone, bk_ref;
   logic [1:0] bk_state;
   logic [hzb_pkg::FAC_W-1:0] bk_factor;
   logic bk_last;

   hzb_back #(
      .ZONES(ZONES),
      .ZW(ZW),
      .IW(IW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .start(start),
      .loaded(loaded),
      .rd_idx(rd_idx),
      .rec(rd_rec),
      .band(band_ff),
      .maint(maint_ff),
      .profile(prof_ff),
      .stat(stat),
      .out_valid(bk_valid),
      .out_full(ofifo_full),
      .out_zone(bk_zone),
      .out_state(bk_state),
      .out_factor(bk_factor),
      .out_ref(bk_ref),
      .out_last(bk_last)
   );

   // two-entry result queue
   logic [RW-1:0] ofifo_ff [2];
   logic [1:0] ocnt_ff, ocnt_in;
   logic wptr_ff, rptr_ff;
   logic opush, opop;

   assign ofifo_full = (ocnt_ff == 2'd2);
   assign rsp_empty = (ocnt_ff == 2'd0);
   assign opush = bk_valid & ~ofifo_full;
   assign opop = rsp_pop & ~rsp_empty;

   always_comb begin
      ocnt_in = ocnt_ff;
      if (opush && !opop) ocnt_in = ocnt_ff + 2'd1;
      else if (opop && !opush) ocnt_in = ocnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ocnt_ff <= '0;
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
      end else begin
         ocnt_ff <= ocnt_in;
         if (opush) wptr_ff <= ~wptr_ff;
         if (opop) rptr_ff <= ~rptr_ff;
      end
      if (opush) ofifo_ff[wptr_ff] <= {bk_zone, bk_state, bk_factor, bk_ref, bk_last};
   end

   assign {rsp_out_zone, rsp_zone_state, rsp_valve_factor, rsp_reference_zone, rsp_out_last}
      = ofifo_ff[rptr_ff];

   `HZB_ASSERT_IMP(a_ocnt_range, clock, reset, 1'b1, ocnt_ff != 2'd3)
   `HZB_ASSERT_IMP(a_no_take_busy, clock, reset, req_push && !req_full, !stat.busy)
   `HZB_ASSERT_NEXT(a_clear_loaded, clock, reset, stat.clear, loaded == '0 && !stat.busy)
   `HZB_ASSERT_IMP(a_start_idle, clock, reset, start, !stat.busy && !bk_valid)
endmodule

>>> rtl/core/hzb_div.sv
`timescale 1ns / 1ps
module hzb_div #(
   parameter int NW = hzb_pkg::NUM_W,
   parameter int DW = hzb_pkg::DEN_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quot
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic          ge;

   assign trial = {r_ff[DW-1:0], q_ff[NW-1]};
   assign ge = trial >= {1'b0, d_ff};

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         // one quotient bit a cycle
         q_in = {q_ff[NW-2:0], ge};
         r_in = ge ? (trial - {1'b0, d_ff}) : trial;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         cnt_in = CW'(NW);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

>>> rtl/core/hzb_front.sv
`timescale 1ns / 1ps
module hzb_front #(
   parameter int ZONES = hzb_pkg::ZONES_DEF,
   parameter int ZW = $clog2(ZONES + 1),
   parameter int IW = (ZONES > 1) ? $clog2(ZONES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [ZW-1:0]         zone_index,
   input  hzb_pkg::zone_rec_type rec_wr,
   input  logic                  last,
   input  logic [IW-1:0]         rd_idx,
   output hzb_pkg::zone_rec_type rd_rec,
   output logic [ZONES-1:0]      loaded,
   output logic                  start,
   input  hzb_pkg::back_stat_type stat
);
   hzb_pkg::zone_rec_type rec_ff [ZONES];
   logic [ZONES-1:0] loaded_ff, loaded_in;
   logic pend_ff, pend_in;
   logic accept, in_range;

   assign full = pend_ff | stat.busy;
   assign accept = push & ~full;
   assign in_range = zone_index < ZW'(ZONES);
   assign start = pend_ff & ~stat.busy;

   always_comb begin
      loaded_in = loaded_ff;
      if (stat.clear) begin
         loaded_in = '0;
      end else if (accept && in_range) begin
         for (int i = 0; i < ZONES; i++) begin
            if (zone_index[IW-1:0] == IW'(i)) loaded_in[i] = 1'b1;
         end
      end
      pend_in = pend_ff;
      if (accept && last) begin
         pend_in = 1'b1;
      end else if (start) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         loaded_ff <= loaded_in;
         pend_ff <= pend_in;
      end
      if (accept && in_range) rec_ff[zone_index[IW-1:0]] <= rec_wr;
   end

   assign rd_rec = rec_ff[rd_idx];
   assign loaded = loaded_ff;
endmodule

>>> rtl/core/hzb_back.sv
`timescale 1ns / 1ps
module hzb_back #(
   parameter int ZONES = hzb_pkg::ZONES_DEF,
   parameter int ZW = $clog2(ZONES + 1),
   parameter int IW = (ZONES > 1) ? $clog2(ZONES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ZONES-1:0]              loaded,
   output logic [IW-1:0]                 rd_idx,
   input  hzb_pkg::zone_rec_type         rec,
   input  logic [9:0]                    band,
   input  logic [13:0]                   maint,
   input  logic [1:0]                    profile,
   output hzb_pkg::back_stat_type        stat,
   output logic                          out_valid,
   input  logic                          out_full,
   output logic [ZW-1:0]                 out_zone,
   output logic [1:0]                    out_state,
   output logic [hzb_pkg::FAC_W-1:0]     out_factor,
   output logic [ZW-1:0]                 out_ref,
   output logic                          out_last
);
   localparam int NW = hzb_pkg::NUM_W;
   localparam int DW = hzb_pkg::DEN_W;
   localparam int LW = hzb_pkg::LEN_W;
   localparam int FW = hzb_pkg::FAC_W;
   localparam int P1W = hzb_pkg::P1_W;
   localparam int P2W = hzb_pkg::P2_W;

   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001,
      S_CLS  = 11'b00000000010,
      S_LEN  = 11'b00000000100,
      S_FLR  = 11'b00000001000,
      S_FDIV = 11'b00000010000,
      S_MC   = 11'b00000100000,
      S_MB   = 11'b00001000000,
      S_ML   = 11'b00010000000,
      S_VST  = 11'b00100000000,
      S_VDIV = 11'b01000000000,
      S_OUT  = 11'b10000000000
   } bstate_type;

   bstate_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in, lastz_ff, lastz_in;
   logic [LW-1:0] best_ff, best_in, lpipe_ff, lpipe_in;
   logic [ZW-1:0] refz_ff, refz_in, lzone_ff, lzone_in;
   logic [FW-1:0] fc_ff, fc_in, c_ff, c_in, f_ff, f_in;
   logic [hzb_pkg::P1_W-1:0] p1_ff, p1_in;
   logic [hzb_pkg::P2_W-1:0] p2_ff, p2_in;
   logic [1:0]    st_ff [ZONES];
   logic [LW-1:0] len_ff [ZONES];
   logic [ZONES-1:0] latch_ff;

   logic st_we, latch_we, len_we, latch_wd;
   logic [1:0] st_wd;
   logic [LW-1:0] len_wd;
   logic div_start, div_done;
   logic [NW-1:0] div_num, div_quot;
   logic [DW-1:0] div_den;
   logic cmp_en, step1, step2, clear;

   // classification
   logic signed [16:0] diff, band_s;
   logic [1:0] cls;
   logic latch_new;
   always_comb begin
      diff = {{2{rec.tgt[14]}}, rec.tgt} - {{2{rec.cur[14]}}, rec.cur};
      band_s = {7'd0, band};
      latch_new = latch_ff[idx_ff];
      if (!rec.tvalid) begin
         cls = hzb_pkg::ST_UNKNOWN;
      end else if (diff < -band_s) begin
         cls = hzb_pkg::ST_OVER;
         latch_new = 1'b1;
      end else if (latch_ff[idx_ff] && diff[16]) begin
         cls = hzb_pkg::ST_OVER;
      end else begin
         latch_new = 1'b0;
         cls = (diff <= band_s) ? hzb_pkg::ST_SAT : hzb_pkg::ST_DEMAND;
      end
   end

   // pipe length, floor correction and valve operands
   logic [19:0] len_num;
   logic [9:0]  tsel, tcl;
   logic [10:0] kv;
   logic [23:0] fa, fden;
   logic [40:0] fnum;
   logic [33:0] cprod;
   logic [DW-1:0] vden;
   always_comb begin
      len_num = {4'd0, rec.area} * 20'd10 + {10'd0, rec.spacing} - 20'd1;
      tsel = rec.thvalid ? rec.thick : 10'd150;
      if (tsel < 10'd50) tcl = 10'd50;
      else if (tsel > 10'd400) tcl = 10'd400;
      else tcl = tsel;
      kv = hzb_pkg::floor_k(rec.fkind);
      fa = {13'd0, kv} * 24'd4715 + {14'd0, tcl} * 24'd3780;
      fden = {13'd0, kv} * 24'd10402;
      // add half the divisor to round to nearest
      fnum = {fa, 17'd0} + {18'd0, fden[23:1]};
      cprod = {17'd0, hzb_pkg::pipe_gain(rec.pkind)} * {17'd0, fc_ff};
      vden = DW'(lpipe_ff) * DW'(10000);
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      lastz_in = lastz_ff;
      best_in = best_ff;
      refz_in = refz_ff;
      lpipe_in = lpipe_ff;
      lzone_in = lzone_ff;
      fc_in = fc_ff;
      c_in = c_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      f_in = f_ff;
      st_we = 1'b0;
      st_wd = cls;
      latch_we = 1'b0;
      latch_wd = latch_new;
      len_we = 1'b0;
      len_wd = hzb_pkg::LEN_DEFAULT;
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;
      cmp_en = 1'b0;
      step1 = 1'b0;
      step2 = 1'b0;
      clear = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               idx_in = '0;
               lastz_in = '0;
               best_in = '0;
               refz_in = ZW'(ZONES);
               state_in = S_CLS;
            end
         end
         S_CLS: begin
            if (loaded[idx_ff]) begin
               st_we = 1'b1;
               latch_we = 1'b1;
               lastz_in = idx_ff;
               if (cls != hzb_pkg::ST_OVER) begin
                  if (rec.area != '0 && rec.spacing != '0) begin
                     div_start = 1'b1;
                     div_num = NW'(len_num);
                     div_den = DW'(rec.spacing);
                     state_in = S_LEN;
                  end else begin
                     len_we = 1'b1;
                     cmp_en = 1'b1;
                     step1 = 1'b1;
                  end
               end else begin
                  step1 = 1'b1;
               end
            end else begin
               step1 = 1'b1;
            end
         end
         S_LEN: begin
            if (div_done) begin
               len_we = 1'b1;
               len_wd = div_quot[LW-1:0] + LW'(2);
               cmp_en = 1'b1;
               step1 = 1'b1;
            end
         end
         S_FLR: begin
            if (!loaded[idx_ff]) begin
               step2 = 1'b1;
            end else if (st_ff[idx_ff] == hzb_pkg::ST_OVER) begin
               f_in = '0;
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               div_num = NW'(fnum);
               div_den = DW'(fden);
               state_in = S_FDIV;
            end
         end
         S_FDIV: begin
            if (div_done) begin
               if (div_quot < NW'(hzb_pkg::Q16_ONE)) fc_in = hzb_pkg::Q16_ONE;
               else if (div_quot > NW'(hzb_pkg::FC_MAX)) fc_in = hzb_pkg::FC_MAX;
               else fc_in = div_quot[FW-1:0];
               state_in = S_MC;
            end
         end
         S_MC: begin
            c_in = FW'((cprod + 34'd32768) >> 16);
            state_in = S_MB;
         end
         S_MB: begin
            p1_in = P1W'(maint) * P1W'(c_ff);
            state_in = S_ML;
         end
         S_ML: begin
            p2_in = P2W'(p1_ff) * P2W'(len_ff[idx_ff]);
            state_in = S_VST;
         end
         S_VST: begin
            div_start = 1'b1;
            div_num = NW'({p2_ff, 1'b0}) + NW'(vden);
            div_den = DW'({vden[DW-2:0], 1'b0});
            state_in = S_VDIV;
         end
         S_VDIV: begin
            if (div_done) begin
               if (div_quot > NW'(hzb_pkg::Q16_ONE)) f_in = hzb_pkg::Q16_ONE;
               else f_in = div_quot[FW-1:0];
               if (profile == hzb_pkg::PROF_HEAT_PUMP
                   && st_ff[idx_ff] == hzb_pkg::ST_DEMAND && f_in < hzb_pkg::HP_MIN)
                  f_in = hzb_pkg::HP_MIN;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            out_valid = 1'b1;
            if (!out_full) step2 = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase

      if (cmp_en && len_wd > best_ff) begin
         best_in = len_wd;
         refz_in = ZW'(idx_ff);
      end
      if (step1) begin
         if (idx_ff == IW'(ZONES - 1)) begin
            lpipe_in = (best_in != '0) ? best_in : hzb_pkg::LEN_DEFAULT;
            lzone_in = refz_in;
            idx_in = '0;
            state_in = S_FLR;
         end else begin
            idx_in = idx_ff + 1'b1;
            state_in = S_CLS;
         end
      end
      if (step2) begin
         if (idx_ff == IW'(ZONES - 1)) begin
            clear = 1'b1;
            state_in = S_IDLE;
         end else begin
            idx_in = idx_ff + 1'b1;
            state_in = S_FLR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         latch_ff <= '0;
         lpipe_ff <= '0;
         lzone_ff <= ZW'(ZONES);
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         lpipe_ff <= lpipe_in;
         lzone_ff <= lzone_in;
         if (latch_we) latch_ff[idx_ff] <= latch_wd;
      end
      lastz_ff <= lastz_in;
      best_ff <= best_in;
      refz_ff <= refz_in;
      fc_ff <= fc_in;
      c_ff <= c_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      f_ff <= f_in;
      if (st_we) st_ff[idx_ff] <= st_wd;
      if (len_we) len_ff[idx_ff] <= len_wd;
   end

   hzb_div #(
      .NW(NW),
      .DW(DW)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(div_den),
      .done(div_done),
      .quot(div_quot)
   );

   assign rd_idx = idx_ff;
   assign stat.busy = (state_ff != S_IDLE);
   assign stat.clear = clear;
   assign out_zone = ZW'(idx_ff);
   assign out_state = st_ff[idx_ff];
   assign out_factor = f_ff;
   assign out_ref = lzone_ff;
   assign out_last = (idx_ff == lastz_ff);
endmodule
